[design/tmc_pkg.sv]
// Shared types, constants and helper functions of the transform matrix composer.
package tmc_pkg;

  localparam int unsigned Dim         = 4;
  localparam int unsigned Cells       = Dim * Dim;
  localparam int unsigned IdxW        = $clog2(Cells);
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepW       = $clog2(CordicSteps + 1);
  localparam int unsigned AtanEntries = 24;

  localparam logic signed [31:0] OneQ     = 32'sd65536;
  localparam logic signed [31:0] ZeroQ    = 32'sd0;
  localparam logic signed [19:0] PiQ      = 20'sd205887;
  localparam logic signed [19:0] HalfPiQ  = 20'sd102944;
  localparam logic signed [33:0] InvGainQ = 34'sd39797;

  typedef enum logic [3:0] {
    ACT_IDENTITY = 4'd0,
    ACT_ZERO     = 4'd1,
    ACT_TRANS    = 4'd2,
    ACT_SCALE    = 4'd3,
    ACT_ROTX     = 4'd4,
    ACT_ROTY     = 4'd5,
    ACT_ROTZ     = 4'd6,
    ACT_LOAD     = 4'd7,
    ACT_MUL      = 4'd8,
    ACT_READ     = 4'd9
  } action_e;

  // Kind of right-hand operand used by the multiply sequencer.
  typedef enum logic [2:0] {
    RHS_TRANS = 3'd0,
    RHS_SCALE = 3'd1,
    RHS_ROTX  = 3'd2,
    RHS_ROTY  = 3'd3,
    RHS_ROTZ  = 3'd4,
    RHS_MEM   = 3'd5
  } rhs_kind_e;

  typedef struct packed {
    logic      start;
    rhs_kind_e kind;
  } mac_cmd_t;

  function automatic logic [31:0] atan_entry(input logic [StepW-1:0] i);
    logic [31:0] v;
    begin
      case (i)
        5'd0:    v = 32'd51472;
        5'd1:    v = 32'd30385;
        5'd2:    v = 32'd16055;
        5'd3:    v = 32'd8150;
        5'd4:    v = 32'd4091;
        5'd5:    v = 32'd2047;
        5'd6:    v = 32'd1024;
        5'd7:    v = 32'd512;
        5'd8:    v = 32'd256;
        5'd9:    v = 32'd128;
        5'd10:   v = 32'd64;
        5'd11:   v = 32'd32;
        5'd12:   v = 32'd16;
        5'd13:   v = 32'd8;
        5'd14:   v = 32'd4;
        5'd15:   v = 32'd2;
        5'd16:   v = 32'd1;
        default: v = 32'd0;
      endcase
      atan_entry = v;
    end
  endfunction

  function automatic logic signed [31:0] identity_entry(input logic [IdxW-1:0] i);
    begin
      identity_entry = (i[1:0] == i[3:2]) ? OneQ : ZeroQ;
    end
  endfunction

endpackage

[design/tmc_cordic.sv]
// Iterative CORDIC that produces sine and cosine of an angle, one step per cycle.
module tmc_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [18:0]  angle_i,
  output logic                done_o,
  output logic signed [31:0]  sin_o,
  output logic signed [31:0]  cos_o
);

  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [33:0] z_q, z_d;
  logic [tmc_pkg::StepW-1:0] step_q, step_d;
  logic busy_q, busy_d, flip_q, flip_d, done_q, done_d;
  logic signed [19:0] ang_c;
  logic signed [33:0] dx, dy, at;

  always_comb begin
    ang_c = 20'(angle_i);
    if (ang_c > tmc_pkg::PiQ) ang_c = tmc_pkg::PiQ;
    if (ang_c < -tmc_pkg::PiQ) ang_c = -tmc_pkg::PiQ;
    dx = y_q >>> step_q;
    dy = x_q >>> step_q;
    at = 34'(signed'({1'b0, tmc_pkg::atan_entry(step_q)}));
    x_d = x_q; y_d = y_q; z_d = z_q; step_d = step_q;
    busy_d = busy_q; flip_d = flip_q; done_d = 1'b0;
    if (start_i) begin
      x_d = tmc_pkg::InvGainQ;
      y_d = '0;
      step_d = '0;
      busy_d = 1'b1;
      flip_d = 1'b0;
      z_d = 34'(ang_c);
      if (ang_c > tmc_pkg::HalfPiQ) begin
        z_d = 34'(ang_c - tmc_pkg::PiQ);
        flip_d = 1'b1;
      end else if (ang_c < -tmc_pkg::HalfPiQ) begin
        z_d = 34'(ang_c + tmc_pkg::PiQ);
        flip_d = 1'b1;
      end
    end else if (busy_q) begin
      if (step_q == tmc_pkg::StepW'(tmc_pkg::CordicSteps)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (flip_q) begin
          x_d = -x_q;
          y_d = -y_q;
        end
      end else begin
        if (z_q >= 0) begin
          x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - at;
        end else begin
          x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + at;
        end
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    flip_q <= flip_d;
  end

  assign done_o = done_q;
  assign sin_o = y_q[31:0];
  assign cos_o = x_q[31:0];

`ifndef NO_ASSERTIONS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i |=> busy_q || done_q) else $error("cordic dropped busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("cordic done longer than a cycle");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q)) else $error("cordic done without work");
`endif

endmodule

[design/tmc_mac.sv]
// Shared multiply-accumulate sequencer that right-multiplies the current matrix.
module tmc_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tmc_pkg::mac_cmd_t                    cmd_i,
  input  logic signed [31:0]                   x_i,
  input  logic signed [31:0]                   y_i,
  input  logic signed [31:0]                   z_i,
  input  logic signed [31:0]                   sin_i,
  input  logic signed [31:0]                   cos_i,
  input  logic [tmc_pkg::Cells-1:0][31:0]      cur_i,
  input  logic signed [31:0]                   opnd_i,
  output logic [tmc_pkg::IdxW-1:0]             opnd_addr_o,
  output logic                                 wr_o,
  output logic [tmc_pkg::IdxW-1:0]             wr_idx_o,
  output logic signed [31:0]                   wr_val_o,
  output logic                                 done_o
);

  // Counter: row (2), column (2), k (2). The fetch stage reads the left-hand element and
  // addresses the operand store, the select stage picks the right-hand value once the
  // store has answered, then the product is formed and accumulated.
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  tmc_pkg::rhs_kind_e kind_q;
  logic [tmc_pkg::Cells-1:0][31:0] snap_q;
  logic [1:0] r, c, k;
  logic [tmc_pkg::IdxW-1:0] kc;
  logic signed [31:0] rhs_gen;
  logic f_vld_q, s_vld_q, p_vld_q, a_vld_q;
  logic f_first_q, s_first_q, p_first_q;
  logic f_last_q, s_last_q, p_last_q, a_last_q;
  logic [tmc_pkg::IdxW-1:0] f_cell_q, s_cell_q, p_cell_q, a_cell_q;
  logic signed [31:0] f_lhs_q, f_gen_q, lhs_q, rhs_q;
  logic signed [63:0] prod_q;
  logic signed [47:0] rnd;
  logic signed [49:0] acc_q;

  assign r = cnt_q[5:4];
  assign c = cnt_q[3:2];
  assign k = cnt_q[1:0];
  assign kc = {k, c};
  assign opnd_addr_o = kc;

  always_comb begin
    rhs_gen = tmc_pkg::identity_entry(kc);
    case (kind_q)
      tmc_pkg::RHS_TRANS: begin
        if (c == 2'd3 && k == 2'd0) rhs_gen = x_i;
        if (c == 2'd3 && k == 2'd1) rhs_gen = y_i;
        if (c == 2'd3 && k == 2'd2) rhs_gen = z_i;
      end
      tmc_pkg::RHS_SCALE: begin
        if (kc == 4'd0) rhs_gen = x_i;
        if (kc == 4'd5) rhs_gen = y_i;
        if (kc == 4'd10) rhs_gen = z_i;
      end
      tmc_pkg::RHS_ROTX: begin
        if (kc == 4'd5 || kc == 4'd10) rhs_gen = cos_i;
        if (kc == 4'd6) rhs_gen = -sin_i;
        if (kc == 4'd9) rhs_gen = sin_i;
      end
      tmc_pkg::RHS_ROTY: begin
        if (kc == 4'd0 || kc == 4'd10) rhs_gen = cos_i;
        if (kc == 4'd2) rhs_gen = sin_i;
        if (kc == 4'd8) rhs_gen = -sin_i;
      end
      tmc_pkg::RHS_ROTZ: begin
        if (kc == 4'd0 || kc == 4'd5) rhs_gen = cos_i;
        if (kc == 4'd1) rhs_gen = -sin_i;
        if (kc == 4'd4) rhs_gen = sin_i;
      end
      default: rhs_gen = tmc_pkg::identity_entry(kc);
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (cmd_i.start) begin
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == 6'd63) busy_d = 1'b0;
    end
  end

  assign rnd = 48'((prod_q + 64'sd32768) >>> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      f_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
      a_vld_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
      f_vld_q <= busy_q;
      s_vld_q <= f_vld_q;
      p_vld_q <= s_vld_q;
      a_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      kind_q <= cmd_i.kind;
      snap_q <= cur_i;
    end
    f_lhs_q <= signed'(snap_q[{r, k}]);
    f_gen_q <= rhs_gen;
    f_cell_q <= {r, c};
    f_first_q <= (k == 2'd0);
    f_last_q <= (k == 2'd3);
    lhs_q <= f_lhs_q;
    rhs_q <= (kind_q == tmc_pkg::RHS_MEM) ? opnd_i : f_gen_q;
    s_cell_q <= f_cell_q;
    s_first_q <= f_first_q;
    s_last_q <= f_last_q;
    prod_q <= 64'(lhs_q) * 64'(rhs_q);
    p_cell_q <= s_cell_q;
    p_first_q <= s_first_q;
    p_last_q <= s_last_q;
    if (p_vld_q) acc_q <= (p_first_q ? 50'sd0 : acc_q) + 50'(rnd);
    a_cell_q <= p_cell_q;
    a_last_q <= p_last_q;
  end

  always_comb begin
    wr_o = a_vld_q && a_last_q;
    wr_idx_o = a_cell_q;
    if (acc_q > 50'sd2147483647) wr_val_o = 32'sh7fffffff;
    else if (acc_q < -50'sd2147483648) wr_val_o = 32'sh80000000;
    else wr_val_o = acc_q[31:0];
  end

  assign done_o = wr_o && (a_cell_q == '1);

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !busy_q && !f_vld_q && !s_vld_q && !p_vld_q && !a_vld_q)
    else $error("mac started while busy");
  a_write_pace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o |=> !wr_o) else $error("mac wrote on consecutive cycles");
  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !cmd_i.start && cnt_q != 6'd63 |=> busy_q) else $error("mac stopped early");
`endif

endmodule

[design/transform_matrix_composer.sv]
// Top level of the transform matrix composer: control sequencer, matrix and operand store.
//
// One input channel (s_axis) carries actions; one output channel (m_axis) carries
// the readout. Each accepted transaction holds one action. Identity, zero, load and
// the unused codes finish in the accepting cycle, so the next transaction can follow
// at once. Translate, scale and multiply by operand keep s_axis_tready low after
// acceptance for a start state, 64 multiply-accumulates on the single shared
// multiplier and four pipeline stages; the next one is taken once the last element
// is written. A rotation runs the CORDIC iterations ahead of the multiply. A read
// sends 16 transactions in row-major order, the first once the read state loads the
// output register, tlast on the sixteenth, one per cycle while the receiver is ready;
// when it stalls the output register holds its element and the sequencer waits.
// s_axis_tready is low while an action runs; a read ends when its last element is
// loaded. Reset sets the matrix to identity; the operand store is not cleared and
// must be loaded before use. Codes above the read action are accepted and ignored.
module transform_matrix_composer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: action[3:0], element_index[7:4], element_value[39:8], x[71:40],
  // y[103:72], z[135:104], angle[154:136], zero fill[159:155]
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: out_index[3:0], out_value[35:4], zero fill[39:36]
  output logic [39:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROT   = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_READ  = 5'b01000,
    ST_WAIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [3:0] act;
  logic [tmc_pkg::IdxW-1:0] el_idx;
  logic signed [31:0] el_val;
  logic in_hs;
  logic signed [31:0] x_q, y_q, z_q;
  logic [tmc_pkg::Cells-1:0][31:0] mat_q;
  logic [31:0] opnd_mem [tmc_pkg::Cells];
  logic signed [31:0] opnd_rd_q;
  logic [tmc_pkg::IdxW-1:0] opnd_addr;
  tmc_pkg::mac_cmd_t mac_cmd;
  tmc_pkg::rhs_kind_e kind_q, kind_d;
  logic mac_wr, mac_done, cordic_done, cordic_start;
  logic [tmc_pkg::IdxW-1:0] mac_wr_idx;
  logic signed [31:0] mac_wr_val, sin_w, cos_w;
  logic [tmc_pkg::IdxW-1:0] rd_idx_q, rd_idx_d;
  logic out_vld_q, out_vld_d, out_last_q;
  logic [tmc_pkg::IdxW-1:0] out_idx_q;
  logic [31:0] out_val_q;
  logic out_load;

  assign act    = s_axis_tdata[3:0];
  assign el_idx = s_axis_tdata[7:4];
  assign el_val = s_axis_tdata[39:8];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_hs = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    kind_d = kind_q;
    mac_cmd.start = 1'b0;
    mac_cmd.kind = kind_q;
    cordic_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_hs) begin
          case (act)
            tmc_pkg::ACT_TRANS: begin
              kind_d = tmc_pkg::RHS_TRANS; state_d = ST_WAIT;
            end
            tmc_pkg::ACT_SCALE: begin
              kind_d = tmc_pkg::RHS_SCALE; state_d = ST_WAIT;
            end
            tmc_pkg::ACT_MUL: begin
              kind_d = tmc_pkg::RHS_MEM; state_d = ST_WAIT;
            end
            tmc_pkg::ACT_ROTX: begin
              kind_d = tmc_pkg::RHS_ROTX; state_d = ST_ROT; cordic_start = 1'b1;
            end
            tmc_pkg::ACT_ROTY: begin
              kind_d = tmc_pkg::RHS_ROTY; state_d = ST_ROT; cordic_start = 1'b1;
            end
            tmc_pkg::ACT_ROTZ: begin
              kind_d = tmc_pkg::RHS_ROTZ; state_d = ST_ROT; cordic_start = 1'b1;
            end
            tmc_pkg::ACT_READ: state_d = ST_READ;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_WAIT: begin
        mac_cmd.start = 1'b1;
        state_d = ST_MUL;
      end
      ST_ROT: begin
        if (cordic_done) begin
          mac_cmd.start = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mac_done) state_d = ST_IDLE;
      end
      ST_READ: begin
        if (out_load && rd_idx_q == 4'd15) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_load = (state_q == ST_READ) && (!out_vld_q || m_axis_tready);
  always_comb begin
    rd_idx_d = rd_idx_q;
    out_vld_d = out_vld_q;
    if (m_axis_tvalid && m_axis_tready) out_vld_d = 1'b0;
    if (out_load) begin
      out_vld_d = 1'b1;
      rd_idx_d = rd_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q <= tmc_pkg::RHS_TRANS;
      rd_idx_q <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < tmc_pkg::Cells; i++)
        mat_q[i] <= tmc_pkg::identity_entry(tmc_pkg::IdxW'(i));
    end else begin
      state_q <= state_d;
      kind_q <= kind_d;
      rd_idx_q <= rd_idx_d;
      out_vld_q <= out_vld_d;
      if (in_hs && act == tmc_pkg::ACT_IDENTITY) begin
        for (int i = 0; i < tmc_pkg::Cells; i++)
          mat_q[i] <= tmc_pkg::identity_entry(tmc_pkg::IdxW'(i));
      end else if (in_hs && act == tmc_pkg::ACT_ZERO) begin
        for (int i = 0; i < tmc_pkg::Cells; i++) mat_q[i] <= '0;
      end else if (mac_wr) begin
        mat_q[mac_wr_idx] <= mac_wr_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      x_q <= s_axis_tdata[71:40];
      y_q <= s_axis_tdata[103:72];
      z_q <= s_axis_tdata[135:104];
    end
    if (in_hs && act == tmc_pkg::ACT_LOAD) opnd_mem[el_idx] <= el_val;
    opnd_rd_q <= opnd_mem[opnd_addr];
    if (out_load) begin
      out_idx_q <= rd_idx_q;
      out_val_q <= mat_q[rd_idx_q];
      out_last_q <= (rd_idx_q == 4'd15);
    end
  end

  tmc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (s_axis_tdata[154:136]),
    .done_o  (cordic_done),
    .sin_o   (sin_w),
    .cos_o   (cos_w)
  );

  tmc_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (mac_cmd),
    .x_i         (x_q),
    .y_i         (y_q),
    .z_i         (z_q),
    .sin_i       (sin_w),
    .cos_i       (cos_w),
    .cur_i       (mat_q),
    .opnd_i      (opnd_rd_q),
    .opnd_addr_o (opnd_addr),
    .wr_o        (mac_wr),
    .wr_idx_o    (mac_wr_idx),
    .wr_val_o    (mac_wr_val),
    .done_o      (mac_done)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_val_q, out_idx_q};
  assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_write_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_wr |-> state_q == ST_MUL) else $error("matrix write outside multiply");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("output dropped");
  a_read_only_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_READ)) else $error("stray output");
`endif

endmodule

[verif/transform_matrix_composer_test.sv]
// Self-checking testbench of the transform matrix composer with its own matrix predictor.
`timescale 1ns / 100ps

module transform_matrix_composer_test;

  localparam int unsigned NumItems   = 320;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned EndCycles  = 200;

  typedef logic signed [31:0] mat_t [16];

  typedef struct {
    logic [159:0] data;
    bit           drain;
  } stim_t;

  typedef struct {
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic               last;
  } element_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [39:0]  m_axis_tdata;
  logic         m_axis_tlast;

  stim_t    stim_q[$];
  element_t readout_q[$];
  mat_t     cur_mat;
  mat_t     opnd_mat;
  int       mismatches;
  int       cycles = 0;
  int       send_gap;
  int       recv_stall;
  bit       send_idling;
  bit       recv_idling;
  int       sent;
  int       received;

  transform_matrix_composer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic void set_identity(output mat_t m);
    for (int i = 0; i < 16; i++) begin
      m[i] = (i % 4 == i / 4) ? tmc_pkg::OneQ : tmc_pkg::ZeroQ;
    end
  endfunction

  function automatic void compose_right(input mat_t rhs);
    mat_t   res;
    longint acc;
    longint prod;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) begin
          prod = longint'(cur_mat[r*4+k]) * longint'(rhs[k*4+c]);
          acc += (prod + 64'sd32768) >>> 16;
        end
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        res[r*4+c] = acc[31:0];
      end
    end
    cur_mat = res;
  endfunction

  function automatic void cordic_sin_cos(input logic signed [18:0] ang_in,
                                         output longint sn, output longint cs);
    longint atan_tab [17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                              256, 128, 64, 32, 16, 8, 4, 2, 1};
    longint ang;
    longint cx;
    longint cy;
    longint dx;
    longint dy;
    bit     flip;
    ang  = ang_in;
    flip = 1'b0;
    if (ang > longint'(tmc_pkg::PiQ)) ang = tmc_pkg::PiQ;
    if (ang < -longint'(tmc_pkg::PiQ)) ang = -longint'(tmc_pkg::PiQ);
    if (ang > longint'(tmc_pkg::HalfPiQ)) begin
      ang -= tmc_pkg::PiQ;
      flip = 1'b1;
    end else if (ang < -longint'(tmc_pkg::HalfPiQ)) begin
      ang += tmc_pkg::PiQ;
      flip = 1'b1;
    end
    cx = tmc_pkg::InvGainQ;
    cy = 0;
    for (int i = 0; i < tmc_pkg::CordicSteps; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (ang >= 0) begin
        cx -= dx;
        cy += dy;
        ang -= (i < 17) ? atan_tab[i] : 0;
      end else begin
        cx += dx;
        cy -= dy;
        ang += (i < 17) ? atan_tab[i] : 0;
      end
    end
    cs = flip ? -cx : cx;
    sn = flip ? -cy : cy;
  endfunction

  function automatic void predict_action(input logic [159:0] d);
    logic [3:0]         act;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    mat_t               t;
    longint             sn;
    longint             cs;
    element_t           e;
    act = d[3:0];
    px  = d[71:40];
    py  = d[103:72];
    pz  = d[135:104];
    set_identity(t);
    cordic_sin_cos(d[154:136], sn, cs);
    case (act)
      tmc_pkg::ACT_IDENTITY: set_identity(cur_mat);
      tmc_pkg::ACT_ZERO: begin
        for (int i = 0; i < 16; i++) cur_mat[i] = tmc_pkg::ZeroQ;
      end
      tmc_pkg::ACT_TRANS: begin
        t[3]  = px;
        t[7]  = py;
        t[11] = pz;
        compose_right(t);
      end
      tmc_pkg::ACT_SCALE: begin
        t[0]  = px;
        t[5]  = py;
        t[10] = pz;
        compose_right(t);
      end
      tmc_pkg::ACT_ROTX: begin
        t[5]  = cs[31:0];
        t[6]  = 32'(-sn);
        t[9]  = sn[31:0];
        t[10] = cs[31:0];
        compose_right(t);
      end
      tmc_pkg::ACT_ROTY: begin
        t[0]  = cs[31:0];
        t[2]  = sn[31:0];
        t[8]  = 32'(-sn);
        t[10] = cs[31:0];
        compose_right(t);
      end
      tmc_pkg::ACT_ROTZ: begin
        t[0] = cs[31:0];
        t[1] = 32'(-sn);
        t[4] = sn[31:0];
        t[5] = cs[31:0];
        compose_right(t);
      end
      tmc_pkg::ACT_LOAD: opnd_mat[d[7:4]] = d[39:8];
      tmc_pkg::ACT_MUL: compose_right(opnd_mat);
      tmc_pkg::ACT_READ: begin
        for (int i = 0; i < 16; i++) begin
          e.idx  = 4'(i);
          e.val  = cur_mat[i];
          e.last = (i == 15);
          readout_q.push_back(e);
        end
      end
      default: ;
    endcase
  endfunction

  // Driver: presents queued actions with random gaps, predicts each accepted transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    stim_t st;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap      <= 0;
      send_idling   <= 1'b1;
      sent          <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_action(s_axis_tdata);
        sent <= sent + 1;
        if (sent % 40 == 39) send_idling <= ~send_idling;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_gap > 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (stim_q.size() > 0 &&
                     !(stim_q[0].drain && readout_q.size() > 0)) begin
          st = stim_q.pop_front();
          s_axis_tdata  <= st.data;
          s_axis_tvalid <= 1'b1;
          send_gap      <= send_idling ? $urandom_range(0, 19) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and comparison against the predicted readout.
  always @(posedge clk_i or negedge rst_ni) begin
    element_t e;
    int       s;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall    <= 0;
      recv_idling   <= 1'b0;
      mismatches    <= 0;
      received      <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        received <= received + 1;
        if (received % 300 == 299) recv_idling <= ~recv_idling;
        if (readout_q.size() == 0) begin
          if (mismatches < 10)
            $display("Unexpected transaction: index %0d value %0d last %0b",
                     m_axis_tdata[3:0], $signed(m_axis_tdata[35:4]), m_axis_tlast);
          mismatches <= mismatches + 1;
        end else begin
          e = readout_q.pop_front();
          if (m_axis_tdata[3:0] !== e.idx || m_axis_tdata[35:4] !== e.val ||
              m_axis_tlast !== e.last) begin
            if (mismatches < 10)
              $display("Mismatch: expected index %0d value %0d last %0b, got %0d %0d %0b",
                       e.idx, e.val, e.last, m_axis_tdata[3:0],
                       $signed(m_axis_tdata[35:4]), m_axis_tlast);
            mismatches <= mismatches + 1;
          end
        end
        s = recv_idling ? $urandom_range(0, 19) : 0;
        m_axis_tready <= (s == 0);
        recv_stall    <= (s > 0) ? s - 1 : 0;
      end else if (recv_stall > 0) begin
        recv_stall    <= recv_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [159:0] pack_action(logic [3:0] act, logic [3:0] idx,
                                               logic [31:0] ev, logic [31:0] px,
                                               logic [31:0] py, logic [31:0] pz,
                                               logic [18:0] ang);
    return {5'b0, ang, pz, py, px, ev, idx, act};
  endfunction

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 262143) - 131072;
      2: return ($urandom_range(0, 1) ? tmc_pkg::OneQ : -tmc_pkg::OneQ) +
                $urandom_range(0, 8191) - 4096;
      3: return $urandom_range(0, 65535) - 32768;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return tmc_pkg::ZeroQ;
          default: return tmc_pkg::OneQ;
        endcase
      end
    endcase
  endfunction

  function automatic logic [18:0] rand_angle();
    if ($urandom_range(0, 5) == 0) return 19'($urandom_range(0, 524287));
    return 19'($urandom_range(0, 411774) - 205887);
  endfunction

  task automatic queue_action(logic [159:0] d, bit drain = 1'b0);
    stim_t st;
    st.data  = d;
    st.drain = drain;
    stim_q.push_back(st);
  endtask

  initial begin
    logic [15:0] loaded;
    logic [3:0]  act;
    logic [3:0]  li;
    int          count;
    int          seq_len;
    bit          first_read;
    rst_ni        = 1'b0;
    loaded        = '0;
    first_read    = 1'b1;
    set_identity(cur_mat);
    for (int i = 0; i < 16; i++) opnd_mat[i] = tmc_pkg::ZeroQ;

    queue_action(pack_action(tmc_pkg::ACT_READ, 0, 0, 0, 0, 0, 0));
    queue_action(pack_action(tmc_pkg::ACT_TRANS, 0, 0, 32'h7fff_ffff, 32'h8000_0000,
                             tmc_pkg::OneQ, 0));
    queue_action(pack_action(tmc_pkg::ACT_SCALE, 0, 0, 32'h7fff_ffff, 32'h8000_0000,
                             tmc_pkg::ZeroQ, 0));
    queue_action(pack_action(tmc_pkg::ACT_READ, 0, 0, 0, 0, 0, 0));
    queue_action(pack_action(tmc_pkg::ACT_ZERO, 0, 0, 0, 0, 0, 0));
    queue_action(pack_action(tmc_pkg::ACT_READ, 0, 0, 0, 0, 0, 0));
    queue_action(pack_action(tmc_pkg::ACT_IDENTITY, 0, 0, 0, 0, 0, 0));
    queue_action(pack_action(tmc_pkg::ACT_ROTX, 0, 0, 0, 0, 0, 19'sd205887));
    queue_action(pack_action(tmc_pkg::ACT_ROTY, 0, 0, 0, 0, 0, -19'sd205887));
    queue_action(pack_action(tmc_pkg::ACT_ROTZ, 0, 0, 0, 0, 0, 19'sd102944));
    queue_action(pack_action(tmc_pkg::ACT_ROTX, 0, 0, 0, 0, 0, 19'sd102945));
    queue_action(pack_action(tmc_pkg::ACT_ROTY, 0, 0, 0, 0, 0, -19'sd102945));
    queue_action(pack_action(tmc_pkg::ACT_ROTZ, 0, 0, 0, 0, 0, 19'h3ffff));
    queue_action(pack_action(tmc_pkg::ACT_ROTX, 0, 0, 0, 0, 0, 19'h40000));
    queue_action(pack_action(tmc_pkg::ACT_ROTZ, 0, 0, 0, 0, 0, 0));
    queue_action(pack_action(4'd10, 4'hf, '1, '1, '1, '1, '1));
    queue_action(pack_action(4'd15, 0, 0, 0, 0, 0, 0));
    queue_action(pack_action(tmc_pkg::ACT_READ, 0, 0, 0, 0, 0, 0));
    queue_action(pack_action(tmc_pkg::ACT_LOAD, 4'd0, 32'h8000_0000, 0, 0, 0, 0));
    queue_action(pack_action(tmc_pkg::ACT_LOAD, 4'd15, 32'h7fff_ffff, 0, 0, 0, 0));
    loaded[0]  = 1'b1;
    loaded[15] = 1'b1;
    count = 20;

    // Random part: runs of transforms and operand work, usually closed by a readout.
    while (count < NumItems) begin
      if ($urandom_range(0, 3) == 0)
        queue_action(pack_action($urandom_range(0, 1) ? tmc_pkg::ACT_IDENTITY :
                                 tmc_pkg::ACT_ZERO,
                                 $urandom(), $urandom(), $urandom(), $urandom(),
                                 $urandom(), $urandom()));
      seq_len = $urandom_range(1, 6);
      for (int n = 0; n < seq_len; n++) begin
        act = 4'($urandom_range(tmc_pkg::ACT_TRANS, tmc_pkg::ACT_MUL));
        if (act == tmc_pkg::ACT_MUL && loaded != 16'hffff) begin
          act = tmc_pkg::ACT_LOAD;
        end
        if (act == tmc_pkg::ACT_LOAD) begin
          li = 4'($urandom());
          if (loaded != 16'hffff && $urandom_range(0, 1))
            while (loaded[li]) li = li + 1'b1;
          loaded[li] = 1'b1;
          queue_action(pack_action(tmc_pkg::ACT_LOAD, li, rand_q(), $urandom(), $urandom(),
                                   $urandom(), $urandom()));
        end else begin
          queue_action(pack_action(act, $urandom(), $urandom(), rand_q(), rand_q(),
                                   rand_q(), rand_angle()));
        end
        count++;
      end
      if ($urandom_range(0, 15) == 0) begin
        queue_action(pack_action($urandom_range(10, 15), $urandom(), $urandom(),
                                 $urandom(), $urandom(), $urandom(), $urandom()));
        count++;
      end
      if ($urandom_range(0, 9) != 0) begin
        queue_action(pack_action(tmc_pkg::ACT_READ, $urandom(), $urandom(), $urandom(),
                                 $urandom(), $urandom(), $urandom()),
                     first_read || $urandom_range(0, 24) == 0);
        first_read = 1'b0;
        count++;
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (readout_q.size() > 0) @(posedge clk_i);
    repeat (EndCycles) @(posedge clk_i);

    if (mismatches == 0 && readout_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
